// ----- sv/utf8_validating_decoder_macros.svh -----
// Assertion macros shared by the decoder RTL.
`ifndef UTF8_VALIDATING_DECODER_MACROS_SVH
`define UTF8_VALIDATING_DECODER_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on clk, off during reset.
`define UVD_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, checked on clk, off during reset.
`define UVD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define UVD_ASSERT_IMPL(lbl, ante, cons, msg)
`define UVD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- sv/utf8vd_pkg.sv -----
// Shared types and constants of the UTF-8 validating decoder.
`timescale 1ns / 1ps
package utf8vd_pkg;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam logic [20:0] REPL_CHAR = 21'h00FFFD;

	localparam logic [7:0] LEAD_E0 = 8'hE0;
	localparam logic [7:0] LEAD_ED = 8'hED;
	localparam logic [7:0] LEAD_F0 = 8'hF0;
	localparam logic [7:0] LEAD_F4 = 8'hF4;

	// Work for one accepted byte: replacements for a flushed sequence, then
	// at most one trailing result.
	typedef struct packed {
		logic [1:0]  n_repl;
		logic        has_tail;
		logic [20:0] tail_cp;
		logic        tail_rep;
		logic [2:0]  tail_cnt;
	} job_t;

endpackage

// ----- sv/utf8vd_front.sv -----
// Front end: accepts bytes, tracks the open sequence and classifies each beat into a job.
`timescale 1ns / 1ps
module utf8vd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [7:0]         data_byte,
	input  logic               end_of_input,
	output logic               job_valid,
	output utf8vd_pkg::job_t   job
);
	import utf8vd_pkg::*;

	logic [1:0]  pend_q, pend_d;
	logic [2:0]  exp_q, exp_d;
	logic [7:0]  lead_q, lead_d;
	logic [20:0] part_q, part_d;

	logic        cont_ok;
	logic [1:0]  pend_inc;
	logic [20:0] part_shift;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			exp_q  <= '0;
			lead_q <= '0;
			part_q <= '0;
		end else if (accept) begin
			pend_q <= pend_d;
			exp_q  <= exp_d;
			lead_q <= lead_d;
			part_q <= part_d;
		end
	end

	always_comb begin
		pend_inc   = pend_q + 2'd1;
		part_shift = {part_q[14:0], data_byte[5:0]};
		cont_ok    = (data_byte[7:6] == 2'b10);
		if (pend_q == 2'd1) begin
			case (lead_q)
				LEAD_E0: cont_ok = cont_ok && (data_byte >= 8'hA0);
				LEAD_ED: cont_ok = cont_ok && (data_byte < 8'hA0);
				LEAD_F0: cont_ok = cont_ok && (data_byte >= 8'h90);
				LEAD_F4: cont_ok = cont_ok && (data_byte <= 8'h8F);
				default: ;
			endcase
		end

		pend_d       = pend_q;
		exp_d        = exp_q;
		lead_d       = lead_q;
		part_d       = part_q;
		job.n_repl   = 2'd0;
		job.has_tail = 1'b0;
		job.tail_cp  = REPL_CHAR;
		job.tail_rep = 1'b1;
		job.tail_cnt = 3'd1;

		if (end_of_input) begin
			// flush whatever is buffered
			job.n_repl = pend_q;
			pend_d     = '0;
			exp_d      = '0;
			lead_d     = '0;
			part_d     = '0;
		end else if (pend_q != 2'd0 && cont_ok) begin
			if ({1'b0, pend_inc} == exp_q || pend_inc == 2'd0) begin
				job.has_tail = 1'b1;
				job.tail_cp  = part_shift;
				job.tail_rep = 1'b0;
				job.tail_cnt = exp_q;
				pend_d       = '0;
				exp_d        = '0;
				lead_d       = '0;
				part_d       = '0;
			end else begin
				pend_d = pend_inc;
				part_d = part_shift;
			end
		end else begin
			// drop the open sequence, then decode the byte afresh
			job.n_repl = pend_q;
			pend_d     = '0;
			exp_d      = '0;
			lead_d     = '0;
			part_d     = '0;
			if (data_byte inside {[8'h00:8'h7F]}) begin
				job.has_tail = 1'b1;
				job.tail_cp  = {13'd0, data_byte};
				job.tail_rep = 1'b0;
			end else if (data_byte inside {[8'hC2:8'hDF]}) begin
				lead_d = data_byte;
				part_d = {16'd0, data_byte[4:0]};
				exp_d  = 3'd2;
				pend_d = 2'd1;
			end else if (data_byte inside {[8'hE0:8'hEF]}) begin
				lead_d = data_byte;
				part_d = {17'd0, data_byte[3:0]};
				exp_d  = 3'd3;
				pend_d = 2'd1;
			end else if (data_byte inside {[8'hF0:8'hF4]}) begin
				lead_d = data_byte;
				part_d = {18'd0, data_byte[2:0]};
				exp_d  = 3'd4;
				pend_d = 2'd1;
			end else begin
				job.has_tail = 1'b1;
			end
		end
		job_valid = accept && (job.has_tail || job.n_repl != 2'd0);
	end

endmodule

// ----- sv/utf8vd_queue.sv -----
// Short job queue between the front and back ends.
`timescale 1ns / 1ps
`include "utf8_validating_decoder_macros.svh"
module utf8vd_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  utf8vd_pkg::job_t push_job,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output utf8vd_pkg::job_t head_job
);
	import utf8vd_pkg::*;

	job_t              entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;

	assign full       = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_job   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: ;
			endcase
		end
	end

	`UVD_ASSERT_IMPL(a_no_push_full, full, !push, "job pushed into a full queue")
	`UVD_ASSERT_IMPL(a_no_pop_empty, !head_valid, !pop, "job popped from an empty queue")
endmodule

// ----- sv/utf8vd_back.sv -----
// Back end: expands each queued job into result beats.
`timescale 1ns / 1ps
`include "utf8_validating_decoder_macros.svh"
module utf8vd_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  utf8vd_pkg::job_t head_job,
	output logic             pop,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [23:0]      m_tdata,
	output logic             m_tuser,
	output logic             m_tlast
);
	import utf8vd_pkg::*;

	logic [1:0]  idx_q;
	logic [2:0]  total;
	logic        in_repl;
	logic [20:0] cp;
	logic [2:0]  cnt;

	always_comb begin
		total    = {1'b0, head_job.n_repl} + {2'b00, head_job.has_tail};
		in_repl  = (idx_q < head_job.n_repl);
		cp       = in_repl ? REPL_CHAR : head_job.tail_cp;
		cnt      = in_repl ? 3'd1 : head_job.tail_cnt;
		m_tuser  = in_repl ? 1'b1 : head_job.tail_rep;
		m_tlast  = (({1'b0, idx_q} + 3'd1) == total);
		m_tdata  = {cnt, cp};
		m_tvalid = head_valid;
		pop      = head_valid && m_tready && m_tlast;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (m_tvalid && m_tready) begin
			idx_q <= m_tlast ? 2'd0 : idx_q + 2'd1;
		end
	end

	`UVD_ASSERT_IMPL(a_job_nonempty, m_tvalid, total != 3'd0, "queued job holds no result")
	`UVD_ASSERT_NEXT(a_idx_clear, m_tvalid && m_tready && m_tlast, idx_q == 2'd0,
		"result index not cleared after last beat")
endmodule

// ----- sv/utf8_validating_decoder.sv -----
// Top level of the UTF-8 validating decoder.
//
// Usage:
//   Slave stream s_*: one beat per raw byte. s_tdata[7:0] carries the byte;
//   s_tlast marks end of input, in which case the byte is ignored and any
//   open sequence is flushed as replacement characters.
//   Master stream m_*: one beat per decoded result. m_tdata[20:0] is the code
//   point, m_tdata[23:21] the number of input bytes it stands for, m_tuser
//   flags a U+FFFD replacement and m_tlast marks the final result of a byte.
//   A completing byte's result is registered in the job queue first.
//   Throughput: one byte per cycle while each byte gives at most one result
//   and m_tready stays high; a byte that breaks a sequence gives up to four
//   beats, one per ready cycle, set by the back end's single result port.
//   Reset clears the open sequence and empties the four-entry job queue.
//   When the receiver stalls, the queue absorbs up to four jobs before
//   s_tready falls; bytes that give no result never occupy it.
`timescale 1ns / 1ps
module utf8_validating_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // end_of_input
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [20:0] code_point, [23:21] byte_count
	output logic        m_tuser,   // [0] replaced
	output logic        m_tlast    // last result of the input beat
);
	import utf8vd_pkg::*;

	logic accept;
	logic q_full;
	logic job_valid;
	job_t job;
	logic head_valid;
	job_t head_job;
	logic pop;

	// Hold off input only when there is no room for a further job.
	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	// Classify each byte and advance the sequence state.
	utf8vd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.data_byte    (s_tdata),
		.end_of_input (s_tlast),
		.job_valid    (job_valid),
		.job          (job)
	);

	// Decouple classification from result delivery.
	utf8vd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (job_valid),
		.push_job   (job),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	// Expand each job into one beat per result.
	utf8vd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule

// ----- test/utf8_validating_decoder_tb.sv -----
// Self-checking testbench for the UTF-8 validating decoder.
`timescale 1ns / 1ps
module utf8_validating_decoder_tb;
	import utf8vd_pkg::*;

	// One decoded result as it leaves the master side.
	typedef struct {
		logic [20:0] cp;
		logic        rep;
		logic [2:0]  cnt;
		logic        last;
	} scalar_t;

	// One row of the directed table. Rows marked typed carry their own answer
	// (zero or one result); the rest are left to the decoding model below.
	typedef struct {
		logic [7:0]  b;
		logic        eoi;
		logic        typed;
		logic        has_one;
		logic [20:0] cp;
		logic        rep;
		logic [2:0]  cnt;
	} probe_t;

	localparam int RANDOM_BEATS = 400;
	localparam int HOLD_CYCLES  = 200;
	localparam int SHOW_LIMIT   = 10;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	// Open sequence as the decoding model sees it.
	logic [1:0]  open_cnt;
	logic [2:0]  open_len;
	logic [7:0]  open_lead;
	logic [20:0] open_point;

	scalar_t fresh_scalars[$];
	scalar_t awaited_scalars[$];
	probe_t  probes[$];

	int  mismatches = 0;
	int  beats_sent = 0;
	bit  calm       = 1'b0;
	bit  hold_req   = 1'b0;
	int  hold_left  = 0;

	utf8_validating_decoder uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Decoding model
	// ---------------------------------------------------------------

	function automatic void add_scalar(input logic [20:0] cp, input logic rep,
			input logic [2:0] cnt);
		scalar_t s;
		s.cp   = cp;
		s.rep  = rep;
		s.cnt  = cnt;
		s.last = 1'b0;
		fresh_scalars.push_back(s);
	endfunction

	function automatic void close_sequence();
		open_cnt   = 2'd0;
		open_len   = 3'd0;
		open_lead  = 8'h00;
		open_point = 21'd0;
	endfunction

	// Each buffered byte of an abandoned sequence becomes one replacement.
	function automatic void flush_open();
		for (int i = 0; i < open_cnt; i++)
			add_scalar(REPL_CHAR, 1'b1, 3'd1);
		close_sequence();
	endfunction

	// Narrowed second-byte ranges that keep out overlongs, surrogates and
	// values beyond U+10FFFF.
	function automatic logic second_byte_ok(input logic [7:0] lead, input logic [7:0] b);
		case (lead)
			LEAD_E0: return b >= 8'hA0;
			LEAD_ED: return b < 8'hA0;
			LEAD_F0: return b >= 8'h90;
			LEAD_F4: return b <= 8'h8F;
			default: return 1'b1;
		endcase
	endfunction

	// Work out the results of one accepted beat into fresh_scalars.
	function automatic void decode_byte(input logic [7:0] b, input logic eoi);
		logic cont_ok;
		logic consumed;
		fresh_scalars.delete();
		consumed = 1'b0;
		if (eoi) begin
			flush_open();
			consumed = 1'b1;
		end else if (open_cnt != 2'd0) begin
			cont_ok = (b[7:6] == 2'b10);
			if (cont_ok && open_cnt == 2'd1)
				cont_ok = second_byte_ok(open_lead, b);
			if (cont_ok) begin
				open_point = {open_point[14:0], b[5:0]};
				open_cnt   = open_cnt + 2'd1;
				// a four-byte sequence completes when the count wraps to zero
				if ({1'b0, open_cnt} == open_len || open_cnt == 2'd0) begin
					add_scalar(open_point, 1'b0, open_len);
					close_sequence();
				end
				consumed = 1'b1;
			end else begin
				flush_open();
			end
		end
		if (!consumed) begin
			if (b < 8'h80) begin
				add_scalar({13'd0, b}, 1'b0, 3'd1);
			end else if (b >= 8'hC2 && b <= 8'hDF) begin
				open_lead  = b;
				open_point = {16'd0, b[4:0]};
				open_len   = 3'd2;
				open_cnt   = 2'd1;
			end else if (b >= 8'hE0 && b <= 8'hEF) begin
				open_lead  = b;
				open_point = {17'd0, b[3:0]};
				open_len   = 3'd3;
				open_cnt   = 2'd1;
			end else if (b >= 8'hF0 && b <= 8'hF4) begin
				open_lead  = b;
				open_point = {18'd0, b[2:0]};
				open_len   = 3'd4;
				open_cnt   = 2'd1;
			end else begin
				add_scalar(REPL_CHAR, 1'b1, 3'd1);
			end
		end
	endfunction

	// ---------------------------------------------------------------
	// Slave side
	// ---------------------------------------------------------------

	// Offer one beat after a random gap, wait for the handshake, then predict.
	// Pass predicted = 0 when the caller queues its own answer.
	task automatic send_beat(input logic [7:0] b, input logic eoi, input logic predicted);
		scalar_t s;
		while (!calm && $urandom_range(0, 99) < 20) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= eoi;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		beats_sent++;
		decode_byte(b, eoi);
		if (predicted)
			for (int i = 0; i < fresh_scalars.size(); i++) begin
				s      = fresh_scalars[i];
				s.last = (i == fresh_scalars.size() - 1);
				awaited_scalars.push_back(s);
			end
	endtask

	// Withdraw the slave side and hold until every awaited result is in.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (awaited_scalars.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] pick_second(input logic [7:0] lead);
		case (lead)
			LEAD_E0: return 8'($urandom_range(8'hA0, 8'hBF));
			LEAD_ED: return 8'($urandom_range(8'h80, 8'h9F));
			LEAD_F0: return 8'($urandom_range(8'h90, 8'hBF));
			LEAD_F4: return 8'($urandom_range(8'h80, 8'h8F));
			default: return 8'($urandom_range(8'h80, 8'hBF));
		endcase
	endfunction

	// Mostly well-formed text of every length, with stray bytes, broken and
	// cut-off sequences and end-of-input beats mixed in.
	task automatic send_random_text();
		int         kind;
		logic [7:0] lead;
		kind = $urandom_range(0, 99);
		if (kind < 22) begin
			send_beat(8'($urandom_range(8'h00, 8'h7F)), 1'b0, 1'b1);
		end else if (kind < 36) begin
			send_beat(8'($urandom_range(8'hC2, 8'hDF)), 1'b0, 1'b1);
			send_beat(8'($urandom_range(8'h80, 8'hBF)), 1'b0, 1'b1);
		end else if (kind < 52) begin
			lead = 8'($urandom_range(8'hE0, 8'hEF));
			send_beat(lead, 1'b0, 1'b1);
			send_beat(pick_second(lead), 1'b0, 1'b1);
			send_beat(8'($urandom_range(8'h80, 8'hBF)), 1'b0, 1'b1);
		end else if (kind < 68) begin
			lead = 8'($urandom_range(8'hF0, 8'hF4));
			send_beat(lead, 1'b0, 1'b1);
			send_beat(pick_second(lead), 1'b0, 1'b1);
			send_beat(8'($urandom_range(8'h80, 8'hBF)), 1'b0, 1'b1);
			send_beat(8'($urandom_range(8'h80, 8'hBF)), 1'b0, 1'b1);
		end else if (kind < 82) begin
			// open a sequence, maybe extend it, then hit it with any byte
			lead = 8'($urandom_range(8'hC2, 8'hF4));
			send_beat(lead, 1'b0, 1'b1);
			if ($urandom_range(0, 1) == 1)
				send_beat(pick_second(lead), 1'b0, 1'b1);
			send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
		end else if (kind < 93) begin
			send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
		end else begin
			// the byte rides along but must be ignored
			send_beat(8'($urandom_range(0, 255)), 1'b1, 1'b1);
		end
	endtask

	function automatic void probe(input logic [7:0] b, input logic eoi);
		probes.push_back('{b, eoi, 1'b0, 1'b0, 21'd0, 1'b0, 3'd0});
	endfunction

	function automatic void probe_typed(input logic [7:0] b, input logic eoi,
			input logic has_one, input logic [20:0] cp, input logic rep,
			input logic [2:0] cnt);
		probes.push_back('{b, eoi, 1'b1, has_one, cp, rep, cnt});
	endfunction

	// ---------------------------------------------------------------
	// Master side
	// ---------------------------------------------------------------

	// Random back-pressure, plus one long hold-off counted here on request.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= calm || $urandom_range(0, 99) >= 20;
			end
		end
	end

	function automatic void report_mismatch(input string what, input int want, input int got);
		mismatches++;
		if (mismatches <= SHOW_LIMIT)
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
	endfunction

	// Compare every accepted result beat with the oldest prediction.
	always @(posedge clk) begin : watch_results
		scalar_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (awaited_scalars.size() == 0) begin
				report_mismatch("unexpected beat, code point", 0, m_tdata[20:0]);
			end else begin
				want = awaited_scalars.pop_front();
				if (m_tdata[20:0] != want.cp)
					report_mismatch("code point", want.cp, m_tdata[20:0]);
				if (m_tuser != want.rep)
					report_mismatch("replaced", want.rep, m_tuser);
				if (m_tdata[23:21] != want.cnt)
					report_mismatch("byte count", want.cnt, m_tdata[23:21]);
				if (m_tlast != want.last)
					report_mismatch("last", want.last, m_tlast);
			end
		end
	end

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------

	initial begin
		scalar_t s;
		int      random_start;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = 8'h00;
		s_tlast  = 1'b0;
		close_sequence();

		// Extremes, stray and bad bytes, and an empty end of input.
		probe_typed(8'h00, 1'b0, 1'b1, 21'h00000, 1'b0, 3'd1);
		probe_typed(8'h7F, 1'b0, 1'b1, 21'h0007F, 1'b0, 3'd1);
		probe_typed(8'h80, 1'b0, 1'b1, REPL_CHAR, 1'b1, 3'd1);
		probe_typed(8'hC0, 1'b0, 1'b1, REPL_CHAR, 1'b1, 3'd1);
		probe_typed(8'hC1, 1'b0, 1'b1, REPL_CHAR, 1'b1, 3'd1);
		probe_typed(8'hF5, 1'b0, 1'b1, REPL_CHAR, 1'b1, 3'd1);
		probe_typed(8'hFF, 1'b0, 1'b1, REPL_CHAR, 1'b1, 3'd1);
		probe_typed(8'hA5, 1'b1, 1'b0, 21'd0, 1'b0, 3'd0);
		// Smallest two-byte value.
		probe(8'hC2, 1'b0);
		probe(8'h80, 1'b0);
		// Each restricted second byte, broken just outside its range.
		probe(8'hE0, 1'b0);
		probe(8'h9F, 1'b0);
		probe(8'hED, 1'b0);
		probe(8'hA0, 1'b0);
		probe(8'hF0, 1'b0);
		probe(8'h8F, 1'b0);
		probe(8'hF4, 1'b0);
		probe(8'h90, 1'b0);
		// Largest scalar value.
		probe(8'hF4, 1'b0);
		probe(8'h8F, 1'b0);
		probe(8'hBF, 1'b0);
		probe(8'hBF, 1'b0);
		// Three buffered bytes flushed by end of input.
		probe(8'hF0, 1'b0);
		probe(8'h90, 1'b0);
		probe(8'h80, 1'b0);
		probe(8'h00, 1'b1);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (probes[i]) begin
			send_beat(probes[i].b, probes[i].eoi, !probes[i].typed);
			if (probes[i].typed && probes[i].has_one) begin
				s.cp   = probes[i].cp;
				s.rep  = probes[i].rep;
				s.cnt  = probes[i].cnt;
				s.last = 1'b1;
				awaited_scalars.push_back(s);
			end
		end
		drain_results();

		random_start = beats_sent;
		while (beats_sent - random_start < RANDOM_BEATS) begin
			// long hold-off on the master side while bytes keep coming
			if (beats_sent - random_start >= 50 && beats_sent - random_start < 54)
				hold_req = 1'b1;
			// a stretch with no idling on either side
			calm = (beats_sent - random_start >= 150 && beats_sent - random_start < 260);
			if (beats_sent - random_start >= 300 && beats_sent - random_start < 304)
				drain_results();
			send_random_text();
		end
		calm = 1'b0;

		drain_results();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Stop a hung run.
	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
